// File: rtl/core/multi_channel_byte_pipe_table_defines.svh
// assertion macros for the byte pipe table
`ifndef MULTI_CHANNEL_BYTE_PIPE_TABLE_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_PIPE_TABLE_DEFINES_SVH

// property checked on every clock edge outside reset
`define MCBPT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define MCBPT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/mcbpt_pkg.sv
// ----------------------------------------------------------------------------
// mcbpt_pkg
// shared types and constants of the byte pipe table
// ----------------------------------------------------------------------------
package mcbpt_pkg;

	localparam int SLOTS     = 8;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int QDEPTH    = 256;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int FILL_W    = QAW + 1;
	localparam int MAX_BYTES = 8;
	localparam int CNT_W     = 4;
	localparam int DATA_W    = 64;
	localparam int MEM_AW    = SLOT_W + QAW;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_WRITE   = 3'd1,
		OP_READ    = 3'd2,
		OP_CLOSE_R = 3'd3,
		OP_CLOSE_W = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TABLE_FULL = 3'd1,
		ST_EOF        = 3'd2,
		ST_QUEUE_FULL = 3'd3,
		ST_NOT_OPEN   = 3'd4
	} status_t;

	// classified command passed from front to back
	typedef struct packed {
		logic                is_create;
		logic                is_write;
		logic                is_read;
		logic                is_close_r;
		logic                is_close_w;
		logic [SLOT_W-1:0]   slot;
		logic [CNT_W-1:0]    count;
		logic [DATA_W-1:0]   wdata;
	} cmd_t;

endpackage

// File: rtl/core/mcbpt_front.sv
// ----------------------------------------------------------------------------
// mcbpt_front
// accepts transactions, decodes them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`include "multi_channel_byte_pipe_table_defines.svh"

module mcbpt_front import mcbpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        operation,
	input  logic [2:0]        pipe_id,
	input  logic [CNT_W-1:0]  byte_count,
	input  logic [DATA_W-1:0] write_data,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] used_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec            = '0;
		dec.is_create  = (operation == OP_CREATE);
		dec.is_write   = (operation == OP_WRITE);
		dec.is_read    = (operation == OP_READ);
		dec.is_close_r = (operation == OP_CLOSE_R);
		dec.is_close_w = (operation == OP_CLOSE_W);
		dec.slot       = SLOT_W'(pipe_id);
		dec.count      = (byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES) : byte_count;
		dec.wdata      = write_data;
	end

	assign busy      = (used_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (used_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			used_q <= used_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	`MCBPT_NEVER(a_pop_empty, cmd_pop && !cmd_valid, "pop from empty command queue")
	`MCBPT_NEVER(a_used_range, used_q == 2'd3, "command queue count out of range")
	`MCBPT_ASSERT(a_fill_busy, (used_q == 2'd1) && push && !cmd_pop |=> busy, "queue full not flagged")

endmodule

// File: rtl/core/mcbpt_back.sv
// ----------------------------------------------------------------------------
// mcbpt_back
// carries out pipe commands against slot state and the byte memory
// ----------------------------------------------------------------------------
`include "multi_channel_byte_pipe_table_defines.svh"

module mcbpt_back import mcbpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              done,
	output logic [2:0]        status,
	output logic [2:0]        new_pipe,
	output logic [CNT_W-1:0]  bytes_done,
	output logic [DATA_W-1:0] read_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_WRITE = 5'b00100,
		S_READ  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [QAW-1:0]    head_q   [SLOTS];
	logic [FILL_W-1:0] fill_q   [SLOTS];
	logic [SLOTS-1:0]  in_use_q;
	logic [SLOTS-1:0]  rd_open_q;
	logic [SLOTS-1:0]  wr_open_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [2:0]        pend_idx_q;
	status_t           status_q;
	logic [2:0]        new_pipe_q;
	logic [DATA_W-1:0] rdata_q;

	logic [7:0]        mem [SLOTS*QDEPTH];
	logic [7:0]        mem_q;
	logic              mem_we;
	logic              mem_re;
	logic [MEM_AW-1:0] waddr;
	logic [MEM_AW-1:0] raddr;

	logic [SLOT_W-1:0] cur;
	logic [SLOT_W-1:0] lowest_free;
	logic              any_free;
	logic [QAW-1:0]    tail;

	assign cur = cmd_q.slot;

	always_comb begin
		lowest_free = '0;
		any_free = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				lowest_free = SLOT_W'(i);
				any_free = 1'b1;
			end
		end
	end

	assign tail   = head_q[cur] + fill_q[cur][QAW-1:0];
	assign waddr  = {cur, tail};
	assign raddr  = {cur, head_q[cur]};
	assign mem_we = (state_q == S_WRITE) && (idx_q < cmd_q.count) && (fill_q[cur] < FILL_W'(QDEPTH));
	assign mem_re = (state_q == S_READ) && (idx_q < cmd_q.count) && (fill_q[cur] != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= cmd_q.wdata[idx_q[2:0]*8 +: 8];
		end
		mem_q <= mem[raddr];
	end

	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign done       = (state_q == S_EMIT);
	assign status     = status_q;
	assign new_pipe   = new_pipe_q;
	assign bytes_done = idx_q;
	assign read_data  = rdata_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == S_EXEC) begin
			rdata_q <= '0;
		end else if (pend_q) begin
			rdata_q[pend_idx_q*8 +: 8] <= mem_q;
		end
		pend_idx_q <= idx_q[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_use_q   <= '0;
			rd_open_q  <= '0;
			wr_open_q  <= '0;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			status_q   <= ST_OK;
			new_pipe_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			pend_q <= mem_re;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					idx_q      <= '0;
					new_pipe_q <= '0;
					status_q   <= ST_NOT_OPEN;
					state_q    <= S_EMIT;
					if (cmd_q.is_create) begin
						if (any_free) begin
							in_use_q[lowest_free]  <= 1'b1;
							rd_open_q[lowest_free] <= 1'b1;
							wr_open_q[lowest_free] <= 1'b1;
							head_q[lowest_free]    <= '0;
							fill_q[lowest_free]    <= '0;
							status_q               <= ST_OK;
							new_pipe_q             <= 3'(lowest_free);
						end else begin
							status_q <= ST_TABLE_FULL;
						end
					end else if (in_use_q[cur]) begin
						if (cmd_q.is_write) begin
							status_q <= ST_OK;
							state_q  <= S_WRITE;
						end else if (cmd_q.is_read) begin
							status_q <= ST_OK;
							state_q  <= S_READ;
						end else if (cmd_q.is_close_r && rd_open_q[cur]) begin
							rd_open_q[cur] <= 1'b0;
							status_q       <= ST_OK;
							if (!wr_open_q[cur]) begin
								in_use_q[cur] <= 1'b0;
							end
						end else if (cmd_q.is_close_w && wr_open_q[cur]) begin
							wr_open_q[cur] <= 1'b0;
							status_q       <= ST_OK;
							if (!rd_open_q[cur]) begin
								in_use_q[cur] <= 1'b0;
							end
						end
					end
				end
				S_WRITE: begin
					if (mem_we) begin
						fill_q[cur] <= fill_q[cur] + 1'b1;
						idx_q       <= idx_q + 1'b1;
					end else begin
						// stopped short: queue ran full
						if (idx_q < cmd_q.count) begin
							status_q <= ST_QUEUE_FULL;
						end
						state_q <= S_EMIT;
					end
				end
				S_READ: begin
					if (mem_re) begin
						head_q[cur] <= head_q[cur] + 1'b1;
						fill_q[cur] <= fill_q[cur] - 1'b1;
						idx_q       <= idx_q + 1'b1;
					end else begin
						// last byte lands in rdata on this edge
						if (idx_q < cmd_q.count) begin
							status_q <= ST_EOF;
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MCBPT_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`MCBPT_NEVER(a_count_range, done && (bytes_done > CNT_W'(MAX_BYTES)), "too many bytes moved")
	`MCBPT_NEVER(a_free_closed, ((rd_open_q | wr_open_q) & ~in_use_q) != '0, "open end on free slot")
	`MCBPT_NEVER(a_fill_range, (state_q != S_IDLE) && (fill_q[cur] > FILL_W'(QDEPTH)), "queue fill beyond depth")

endmodule

// File: rtl/core/multi_channel_byte_pipe_table.sv
// Byte pipe table: eight pipes, each a 256-byte FIFO with read and write ends.
// Command channel: drive operation, pipe_id, byte_count and write_data with
// start high; the transaction is taken on a clock edge where busy is low.
// busy rises when the two-entry command queue is full.
// Result channel: done is high for exactly one cycle with status, new_pipe,
// bytes_done and read_data valid; the receiver cannot stall it, every
// transaction gives one result, in order.
// Each transaction passes through the back end states in order: idle, where
// it is popped, execute, then for write and read a write or read state that
// moves the bytes, then emit. The byte memory has one write and one read port,
// so one byte moves per cycle; the command queue can take new transactions
// while the back end is still working on an earlier one.
// Reset (arst_n low) frees all slots and empties the command queue; the byte
// memory is not cleared, a pipe only reads bytes written since its create.
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_table
// top level: command front end, queue and execution back end
// ----------------------------------------------------------------------------
module multi_channel_byte_pipe_table import mcbpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        operation,
	input  logic [2:0]        pipe_id,
	input  logic [CNT_W-1:0]  byte_count,
	input  logic [DATA_W-1:0] write_data,
	output logic              done,
	output logic [2:0]        status,
	output logic [2:0]        new_pipe,
	output logic [CNT_W-1:0]  bytes_done,
	output logic [DATA_W-1:0] read_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	mcbpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.pipe_id    (pipe_id),
		.byte_count (byte_count),
		.write_data (write_data),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	mcbpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.done       (done),
		.status     (status),
		.new_pipe   (new_pipe),
		.bytes_done (bytes_done),
		.read_data  (read_data)
	);

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the byte pipe table against a behavioral model of its slots and fifos
// ----------------------------------------------------------------------------
module tb;
	import mcbpt_pkg::*;

	typedef struct {
		logic [2:0]        st;
		logic [2:0]        pipe;
		logic [CNT_W-1:0]  cnt;
		logic [DATA_W-1:0] data;
	} pipe_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        operation;
	logic [2:0]        pipe_id;
	logic [CNT_W-1:0]  byte_count;
	logic [DATA_W-1:0] write_data;
	logic              done;
	logic [2:0]        status;
	logic [2:0]        new_pipe;
	logic [CNT_W-1:0]  bytes_done;
	logic [DATA_W-1:0] read_data;

	multi_channel_byte_pipe_table uut (.*);

	// model state
	logic [7:0]  fifo_mem [SLOTS][QDEPTH];
	int          head_ptr [SLOTS];
	int          fill_cnt [SLOTS];
	bit          in_use [SLOTS];
	bit          rd_open [SLOTS];
	bit          wr_open [SLOTS];

	pipe_result_t expected_results[$];
	int          errors;
	int          sent;
	int          checked;
	int          cycles;
	int          send_idle_pct;
	bit          hold_sender;

	initial begin
		clk = 1'b0;
	end
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			pipe_result_t e;
			if (expected_results.size() == 0) begin
				$display("unexpected result, status %0d", status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (new_pipe !== e.pipe) report_mismatch("new_pipe", new_pipe, e.pipe);
				if (bytes_done !== e.cnt) report_mismatch("bytes_done", bytes_done, e.cnt);
				if (read_data !== e.data) report_mismatch("read_data", read_data, e.data);
			end
			checked++;
		end
	end

	function automatic pipe_result_t predict_pipe_op(input logic [2:0] op,
			input logic [2:0] id, input logic [3:0] cnt_in, input logic [63:0] wd);
		pipe_result_t r;
		int n;
		int s;
		bit ok_slot;
		r.st = ST_NOT_OPEN;
		r.pipe = '0;
		r.cnt = '0;
		r.data = '0;
		n = (cnt_in > MAX_BYTES) ? MAX_BYTES : cnt_in;
		s = id;
		ok_slot = in_use[s];
		if (op == OP_CREATE) begin
			r.st = ST_TABLE_FULL;
			for (int i = 0; i < SLOTS; i++) begin
				if (!in_use[i]) begin
					in_use[i] = 1;
					rd_open[i] = 1;
					wr_open[i] = 1;
					head_ptr[i] = 0;
					fill_cnt[i] = 0;
					r.st = ST_OK;
					r.pipe = 3'(i);
					break;
				end
			end
		end else if (op == OP_WRITE && ok_slot) begin
			r.st = ST_OK;
			for (int i = 0; i < n; i++) begin
				if (fill_cnt[s] >= QDEPTH) begin
					r.st = ST_QUEUE_FULL;
					break;
				end
				fifo_mem[s][(head_ptr[s] + fill_cnt[s]) % QDEPTH] = wd[8*i +: 8];
				fill_cnt[s]++;
				r.cnt++;
			end
		end else if (op == OP_READ && ok_slot) begin
			r.st = ST_OK;
			for (int i = 0; i < n; i++) begin
				if (fill_cnt[s] == 0) begin
					r.st = ST_EOF;
					break;
				end
				r.data[8*i +: 8] = fifo_mem[s][head_ptr[s]];
				head_ptr[s] = (head_ptr[s] + 1) % QDEPTH;
				fill_cnt[s]--;
				r.cnt++;
			end
		end else if ((op == OP_CLOSE_R || op == OP_CLOSE_W) && ok_slot) begin
			if (op == OP_CLOSE_R && rd_open[s]) begin
				rd_open[s] = 0;
				r.st = ST_OK;
			end else if (op == OP_CLOSE_W && wr_open[s]) begin
				wr_open[s] = 0;
				r.st = ST_OK;
			end
			if (!rd_open[s] && !wr_open[s]) in_use[s] = 0;
		end
		return r;
	endfunction

	// one transaction, driven at the falling edge and held until accepted
	task automatic send_pipe_op(input logic [2:0] op, input logic [2:0] id,
			input logic [3:0] cnt, input logic [63:0] wd);
		while ($urandom_range(99) < send_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		operation = op;
		pipe_id = id;
		byte_count = cnt;
		write_data = wd;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_pipe_op(op, id, cnt, wd));
		sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [63:0] rand_data();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		send_pipe_op(OP_READ, 3'd0, 4'd1, '0);
		send_pipe_op(OP_CLOSE_R, 3'd7, 4'd1, '0);
		for (int i = 0; i < SLOTS; i++) send_pipe_op(OP_CREATE, 3'(i), 4'd1, '0);
		send_pipe_op(OP_CREATE, 3'd0, 4'd1, '0);
		send_pipe_op(OP_WRITE, 3'd0, 4'd15, 64'hffff_ffff_ffff_ffff);
		send_pipe_op(OP_WRITE, 3'd0, 4'd0, '0);
		send_pipe_op(OP_WRITE, 3'd0, 4'd3, 64'h0123_4567_89ab_cdef);
		send_pipe_op(OP_READ, 3'd0, 4'd8, '0);
		send_pipe_op(OP_READ, 3'd0, 4'd15, '0);
		send_pipe_op(3'd5, 3'd0, 4'd1, '0);
		send_pipe_op(3'd7, 3'd0, 4'd1, '0);
		send_pipe_op(OP_CLOSE_R, 3'd1, 4'd1, '0);
		send_pipe_op(OP_CLOSE_R, 3'd1, 4'd1, '0);
		send_pipe_op(OP_WRITE, 3'd1, 4'd2, 64'hbeef);
		send_pipe_op(OP_READ, 3'd1, 4'd2, '0);
		send_pipe_op(OP_CLOSE_W, 3'd1, 4'd1, '0);
		send_pipe_op(OP_CLOSE_W, 3'd1, 4'd1, '0);
		send_pipe_op(OP_CREATE, 3'd5, 4'd1, '0);
		send_pipe_op(OP_READ, 3'd1, 4'd4, '0);
	endtask

	// fill one pipe to the brim to reach queue full, then wrap the tail
	task automatic test_queue_full();
		for (int i = 0; i < QDEPTH / 8 + 2; i++)
			send_pipe_op(OP_WRITE, 3'd2, 4'd8, rand_data());
		send_pipe_op(OP_READ, 3'd2, 4'd5, '0);
		send_pipe_op(OP_WRITE, 3'd2, 4'd8, rand_data());
		for (int i = 0; i < QDEPTH / 8 + 2; i++)
			send_pipe_op(OP_READ, 3'd2, 4'($urandom_range(1, 8)), '0);
	endtask

	task automatic test_random(input int items);
		logic [2:0] op;
		int pick;
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) op = OP_CREATE;
			else if (pick < 50) op = OP_WRITE;
			else if (pick < 88) op = OP_READ;
			else if (pick < 93) op = OP_CLOSE_R;
			else if (pick < 98) op = OP_CLOSE_W;
			else op = 3'($urandom_range(5, 7));
			send_pipe_op(op, 3'($urandom_range(7)), 4'($urandom_range(15)), rand_data());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = '0;
		pipe_id = '0;
		byte_count = '0;
		write_data = '0;
		errors = 0;
		sent = 0;
		checked = 0;
		cycles = 0;
		send_idle_pct = 0;
		for (int i = 0; i < SLOTS; i++) begin
			head_ptr[i] = 0;
			fill_cnt[i] = 0;
			in_use[i] = 0;
			rd_open[i] = 0;
			wr_open[i] = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 36;
		test_directed();
		drain_results();
		test_queue_full();
		send_idle_pct = 61;
		test_random(700);
		drain_results();
		send_idle_pct = 0;
		test_random(1300);
		drain_results();

		$display("sent %0d transactions covering create, write, read, both closes,", sent);
		$display("table full, queue full, end of file and invalid slot or op codes");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
